// ===== hw/rtl/kcped_pkg.sv =====
package kcped_pkg;

	// press tracking phases
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_WAIT   = 3'd1,
		PH_SHORT  = 3'd2,
		PH_DOUBLE = 3'd3,
		PH_LONG   = 3'd4,
		PH_REL    = 3'd5
	} phase_t;

	// event codes carried in the result beat
	typedef enum logic [3:0] {
		EV_NONE       = 4'd0,
		EV_RAW        = 4'd1,
		EV_SHORT      = 4'd2,
		EV_DOUBLE     = 4'd3,
		EV_LONG       = 4'd4,
		EV_REPEAT     = 4'd5,
		EV_SHORT_REL  = 4'd6,
		EV_DOUBLE_REL = 4'd7,
		EV_LONG_REL   = 4'd8,
		EV_RELEASED   = 4'd9
	} event_t;

	// register map, word index
	typedef enum logic [2:0] {
		REG_SHORT_TH  = 3'd0,
		REG_LONG_TH   = 3'd1,
		REG_REPEAT    = 3'd2,
		REG_DBL_WIN   = 3'd3,
		REG_FALLTHRU  = 3'd4,
		REG_DBL_EN    = 3'd5
	} reg_idx_t;

	localparam int unsigned KeyW   = 8;
	localparam int unsigned TimeW  = 32;
	localparam int unsigned CodeW  = 4;
	localparam int unsigned ThW    = 16;
	localparam int unsigned InW    = KeyW + TimeW;   // 40, whole bytes
	localparam int unsigned OutW   = 16;             // 8 + 4 padded to 16
	localparam int unsigned AddrW  = 5;

	localparam logic [ThW-1:0] ShortThRst  = 16'd50;
	localparam logic [ThW-1:0] LongThRst   = 16'd1000;
	localparam logic [ThW-1:0] RepeatRst   = 16'd250;
	localparam logic [ThW-1:0] DblWinRst   = 16'd300;

endpackage

// ===== hw/rtl/key_combo_press_event_detector.sv =====
// channel      | beat fields (low bit first)                  | handshake
// s (input)    | pressed_keys[7:0], now_ms[39:8]              | s_tvalid / s_tready
// m (result)   | event_keys[7:0], event_code[11:8], zero pad  | m_tvalid / m_tready
// apb (config) | six registers at byte addresses 0,4,..,20    | psel & penable, pready = 1
//
// an input beat passes through one input register, then one result
// register; the state update happens as the item moves from the first to the second
// throughput is one beat per cycle while m_tready does not stall the result register
// the input register keeps taking beats while a result waits for m_tready, until it is full
// arst_n clears the press state, the valid flags and restores the register defaults
module key_combo_press_event_detector
	import kcped_pkg::*;
#(
	parameter int unsigned KEY_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [InW-1:0]   s_tdata,   // pressed_keys[7:0], now_ms[39:8]
	// result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OutW-1:0]  m_tdata,   // event_keys[7:0], event_code[11:8], zero [15:12]
	// configuration
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// keys above KEY_BITS are dropped; the port stays eight bits wide
	localparam logic [KeyW-1:0] KeysMask =
		(KEY_BITS >= KeyW) ? {KeyW{1'b1}} : KeyW'((64'd1 << KEY_BITS) - 64'd1);

	// configuration registers
	logic [ThW-1:0] short_th_q, long_th_q, repeat_q, dbl_win_q;
	logic           fallthru_q, dbl_en_q;
	logic           cfg_wr;
	reg_idx_t       cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_th_q <= ShortThRst;
			long_th_q  <= LongThRst;
			repeat_q   <= RepeatRst;
			dbl_win_q  <= DblWinRst;
			fallthru_q <= 1'b0;
			dbl_en_q   <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SHORT_TH: short_th_q <= pwdata[ThW-1:0];
				REG_LONG_TH:  long_th_q  <= pwdata[ThW-1:0];
				REG_REPEAT:   repeat_q   <= pwdata[ThW-1:0];
				REG_DBL_WIN:  dbl_win_q  <= pwdata[ThW-1:0];
				REG_FALLTHRU: fallthru_q <= pwdata[0];
				REG_DBL_EN:   dbl_en_q   <= pwdata[0];
				default: ;   // unmapped words ignore writes
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_SHORT_TH: prdata = {16'd0, short_th_q};
			REG_LONG_TH:  prdata = {16'd0, long_th_q};
			REG_REPEAT:   prdata = {16'd0, repeat_q};
			REG_DBL_WIN:  prdata = {16'd0, dbl_win_q};
			REG_FALLTHRU: prdata = {31'd0, fallthru_q};
			REG_DBL_EN:   prdata = {31'd0, dbl_en_q};
			default:      prdata = 32'd0;
		endcase
	end

	// stage 1: input register
	logic              valid_s1;
	logic [KeyW-1:0]   keys_s1;
	logic [TimeW-1:0]  now_s1;
	logic              advance;

	// stage 2: result register
	logic              valid_s2;
	logic [KeyW-1:0]   ev_keys_s2;
	event_t            ev_code_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			keys_s1 <= s_tdata[KeyW-1:0] & KeysMask;
			now_s1  <= s_tdata[InW-1:KeyW];
		end
	end

	// press state
	phase_t           phase_q, phase_d;
	logic [KeyW-1:0]  held_q, held_d;
	logic [TimeW-1:0] start_q, start_d;
	logic [KeyW-1:0]  prev_mask_q, prev_mask_d;
	logic [TimeW-1:0] prev_time_q, prev_time_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			held_q      <= '0;
			start_q     <= '0;
			prev_mask_q <= '0;
			prev_time_q <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			held_q      <= held_d;
			start_q     <= start_d;
			prev_mask_q <= prev_mask_d;
			prev_time_q <= prev_time_d;
		end
	end

	// time differences wrap modulo 2^32
	logic [TimeW-1:0] elapsed, since_rel;
	logic             new_keys;
	logic [KeyW-1:0]  ev_keys;
	event_t           ev_code;
	logic [KeyW-1:0]  idle_keys;
	event_t           idle_code;

	assign elapsed   = now_s1 - start_q;
	assign since_rel = now_s1 - prev_time_q;
	assign new_keys  = |(keys_s1 & ~held_q);
	// quiet event while nothing fires: raw mask in fallthrough mode
	assign idle_keys = fallthru_q ? keys_s1 : '0;
	assign idle_code = fallthru_q ? EV_RAW : EV_NONE;

	always_comb begin
		phase_d     = phase_q;
		held_d      = held_q;
		start_d     = start_q;
		prev_mask_d = prev_mask_q;
		prev_time_d = prev_time_q;
		ev_keys     = idle_keys;
		ev_code     = idle_code;

		if (phase_q == PH_REL) begin
			// bare released beat, sample ignored
			phase_d = PH_IDLE;
			held_d  = '0;
			ev_keys = '0;
			ev_code = EV_RELEASED;
		end else if (keys_s1 == '0) begin
			held_d  = '0;
			ev_keys = held_q;
			phase_d = PH_REL;
			unique case (phase_q)
				PH_LONG: ev_code = EV_LONG_REL;
				PH_SHORT: begin
					ev_code = EV_SHORT_REL;
					if (dbl_en_q) begin
						prev_mask_d = held_q;
						prev_time_d = now_s1;
					end
				end
				PH_DOUBLE: begin
					ev_code = EV_DOUBLE_REL;
					if (dbl_en_q) begin
						prev_mask_d = '0;
					end
				end
				default: begin
					// released before short confirmation
					phase_d = PH_IDLE;
					ev_keys = '0;
					ev_code = EV_NONE;
				end
			endcase
		end else if (new_keys || phase_q == PH_IDLE) begin
			// more keys: restart timing
			held_d  = held_q | keys_s1;
			phase_d = PH_WAIT;
			start_d = now_s1;
			if (dbl_en_q && since_rel > {16'd0, dbl_win_q}) begin
				prev_mask_d = '0;
			end
		end else if (phase_q == PH_WAIT && elapsed > {16'd0, short_th_q}) begin
			// partial release narrows the mask at confirmation
			held_d  = keys_s1;
			ev_keys = keys_s1;
			if (dbl_en_q && prev_mask_q == keys_s1) begin
				phase_d = PH_DOUBLE;
				ev_code = EV_DOUBLE;
			end else begin
				phase_d = PH_SHORT;
				ev_code = EV_SHORT;
			end
		end else if (phase_q == PH_LONG) begin
			if (elapsed > {16'd0, repeat_q}) begin
				start_d = now_s1;
				ev_keys = held_q;
				ev_code = EV_REPEAT;
			end
		end else if (elapsed > {16'd0, long_th_q}) begin
			phase_d = PH_LONG;
			start_d = now_s1;
			ev_keys = held_q;
			ev_code = EV_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_keys_s2 <= ev_keys;
			ev_code_s2 <= ev_code;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OutW - KeyW - CodeW){1'b0}}, ev_code_s2, ev_keys_s2};

	// checks
	a_rel_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_REL || phase_q == PH_IDLE) |-> held_q == '0)
		else $error("held mask not clear while idle or release pending");

	a_rel_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_REL) |=> phase_q == PH_IDLE)
		else $error("release pending did not return to idle");

	a_held_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q & ~KeysMask) == '0)
		else $error("held mask has keys beyond KEY_BITS");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[KeyW+CodeW-1:KeyW] <= EV_RELEASED)
		else $error("event code out of range");

	a_wait_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT || phase_q == PH_SHORT || phase_q == PH_DOUBLE ||
		 phase_q == PH_LONG) |-> held_q != '0)
		else $error("active press with empty mask");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import kcped_pkg::*;

	localparam int unsigned CycleLimit  = 200000;
	localparam int unsigned HoldCycles  = 200;
	localparam int unsigned RandPhases  = 8;
	localparam int unsigned PhaseItems  = 103;
	localparam int unsigned UnmappedIdx = 7;
	// directed timestamps start just below the wrap point
	localparam logic [31:0] DirBase     = 32'hFFFF_FE00;

	// one result beat as the detector reports it
	typedef struct packed {
		logic [7:0] keys;
		event_t     code;
	} key_event_t;

	// a result typed into the directed table, used instead of the predicted one
	typedef struct packed {
		logic       pin;
		logic [7:0] keys;
		event_t     code;
	} pinned_t;

	typedef struct packed {
		logic [7:0]  keys;
		logic [31:0] offset;
		logic        pin;
		logic [7:0]  exp_keys;
		event_t      exp_code;
	} dir_row_t;

	localparam dir_row_t DirRows [27] = '{
		'{8'h00, 32'd0,    1'b1, 8'h00, EV_NONE},     // nothing held after reset
		'{8'h01, 32'd0,    1'b1, 8'h00, EV_NONE},     // first press starts timing
		'{8'h01, 32'd50,   1'b1, 8'h00, EV_NONE},     // exactly at short threshold
		'{8'h01, 32'd51,   1'b1, 8'h01, EV_SHORT},    // one past short threshold
		'{8'h00, 32'd60,   1'b0, 8'h00, EV_NONE},     // short release
		'{8'hFF, 32'd61,   1'b1, 8'h00, EV_RELEASED}, // pending release drops sample
		'{8'h01, 32'd360,  1'b0, 8'h00, EV_NONE},     // double window edge, kept
		'{8'h01, 32'd411,  1'b0, 8'h00, EV_NONE},     // double
		'{8'h01, 32'd1411, 1'b0, 8'h00, EV_NONE},     // long, across the wrap
		'{8'h01, 32'd1661, 1'b1, 8'h00, EV_NONE},     // exactly at repeat period
		'{8'h01, 32'd1662, 1'b0, 8'h00, EV_NONE},     // repeat
		'{8'h00, 32'd1700, 1'b0, 8'h00, EV_NONE},     // long release
		'{8'h00, 32'd1701, 1'b1, 8'h00, EV_RELEASED},
		'{8'h03, 32'd2000, 1'b0, 8'h00, EV_NONE},     // two keys
		'{8'h02, 32'd2010, 1'b0, 8'h00, EV_NONE},     // partial release narrows
		'{8'h02, 32'd2100, 1'b0, 8'h00, EV_NONE},     // short on narrowed mask
		'{8'h06, 32'd2110, 1'b0, 8'h00, EV_NONE},     // added key restarts
		'{8'h80, 32'd2120, 1'b0, 8'h00, EV_NONE},     // top key added
		'{8'h00, 32'd2130, 1'b1, 8'h00, EV_NONE},     // release before short
		'{8'hFF, 32'd3000, 1'b0, 8'h00, EV_NONE},
		'{8'hFF, 32'd3051, 1'b1, 8'hFF, EV_SHORT},    // full mask
		'{8'h00, 32'd3052, 1'b0, 8'h00, EV_NONE},
		'{8'h00, 32'd3053, 1'b1, 8'h00, EV_RELEASED},
		'{8'hFF, 32'd3100, 1'b0, 8'h00, EV_NONE},
		'{8'hFF, 32'd3200, 1'b0, 8'h00, EV_NONE},     // double on full mask
		'{8'h00, 32'd3201, 1'b0, 8'h00, EV_NONE},     // double release
		'{8'h00, 32'd3202, 1'b1, 8'h00, EV_RELEASED}
	};

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [InW-1:0]    s_tdata  = '0;  // pressed_keys[7:0], now_ms[39:8]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OutW-1:0]   m_tdata;        // event_keys[7:0], event_code[11:8], zero pad
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [AddrW-1:0]  paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;

	// register copies
	logic [15:0] cfg_short_th = ShortThRst;
	logic [15:0] cfg_long_th  = LongThRst;
	logic [15:0] cfg_repeat   = RepeatRst;
	logic [15:0] cfg_dbl_win  = DblWinRst;
	logic        cfg_fallthru = 1'b0;
	logic        cfg_dbl_en   = 1'b1;

	// press tracker copy
	phase_t      trk_phase      = PH_IDLE;
	logic [7:0]  trk_held       = '0;
	logic [31:0] trk_start      = '0;
	logic [7:0]  last_short_mask = '0;
	logic [31:0] last_short_rel  = '0;

	key_event_t  pending_events [$];
	pinned_t     pin_q [$];

	int unsigned error_count  = 0;
	int unsigned samples_sent = 0;
	int unsigned cycle_count  = 0;
	int unsigned hold_left    = 0;
	logic        hold_go      = 1'b0;
	logic        hold_done    = 1'b0;
	logic        tx_idle_on   = 1'b1;
	logic        rx_idle_on   = 1'b1;
	logic [31:0] sample_ms    = '0;
	logic [7:0]  last_mask    = '0;

	key_combo_press_event_detector #(.KEY_BITS(KeyW)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// event while keys are held and nothing is confirmed
	function automatic key_event_t waiting_event(logic [7:0] pressed);
		return cfg_fallthru ? key_event_t'{pressed, EV_RAW} : key_event_t'{8'h00, EV_NONE};
	endfunction

	function automatic key_event_t next_key_event(logic [7:0] pressed, logic [31:0] now);
		key_event_t  ev;
		logic [31:0] elapsed;
		logic [31:0] since_rel;
		if (trk_phase == PH_REL) begin
			trk_phase = PH_IDLE;
			trk_held  = '0;
			return key_event_t'{8'h00, EV_RELEASED};
		end
		if (pressed == '0) begin
			ev = key_event_t'{trk_held, EV_NONE};
			case (trk_phase)
				PH_LONG: begin
					ev.code = EV_LONG_REL;
				end
				PH_SHORT: begin
					if (cfg_dbl_en) begin
						last_short_mask = trk_held;
						last_short_rel  = now;
					end
					ev.code = EV_SHORT_REL;
				end
				PH_DOUBLE: begin
					if (cfg_dbl_en)
						last_short_mask = '0;
					ev.code = EV_DOUBLE_REL;
				end
				default: begin
					ev.keys = '0;
				end
			endcase
			trk_phase = (ev.code == EV_NONE) ? PH_IDLE : PH_REL;
			trk_held  = '0;
			return ev;
		end
		// new keys or a fresh press restart all timing
		if ((pressed & ~trk_held) != '0 || trk_phase == PH_IDLE) begin
			trk_held  = trk_held | pressed;
			trk_phase = PH_WAIT;
			trk_start = now;
			since_rel = now - last_short_rel;
			if (cfg_dbl_en && since_rel > {16'd0, cfg_dbl_win})
				last_short_mask = '0;
			return waiting_event(pressed);
		end
		elapsed = now - trk_start;
		if (trk_phase == PH_WAIT && elapsed > {16'd0, cfg_short_th}) begin
			trk_held = pressed;
			if (cfg_dbl_en && last_short_mask == pressed) begin
				trk_phase = PH_DOUBLE;
				return key_event_t'{pressed, EV_DOUBLE};
			end
			trk_phase = PH_SHORT;
			return key_event_t'{pressed, EV_SHORT};
		end
		if (trk_phase == PH_LONG) begin
			if (elapsed > {16'd0, cfg_repeat}) begin
				trk_start = now;
				return key_event_t'{trk_held, EV_REPEAT};
			end
		end else if (elapsed > {16'd0, cfg_long_th}) begin
			// also taken straight from waiting when long is below short
			trk_phase = PH_LONG;
			trk_start = now;
			return key_event_t'{trk_held, EV_LONG};
		end
		return waiting_event(pressed);
	endfunction

	// predict on every accepted input beat, check every accepted result beat
	always @(posedge clk) begin : beat_check
		key_event_t ev;
		key_event_t want;
		pinned_t    pin;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				ev  = next_key_event(s_tdata[7:0], s_tdata[39:8]);
				pin = pin_q.pop_front();
				if (pin.pin)
					ev = key_event_t'{pin.keys, pin.code};
				pending_events.push_back(ev);
			end
			if (m_tvalid && m_tready) begin
				if (pending_events.size() == 0) begin
					$error("result beat %h with no event pending", m_tdata);
					error_count++;
				end else begin
					want = pending_events.pop_front();
					if (m_tdata[7:0] != want.keys) begin
						$error("event_keys: expected %0h, got %0h", want.keys, m_tdata[7:0]);
						error_count++;
					end
					if (m_tdata[11:8] != want.code) begin
						$error("event_code: expected %0d, got %0d", want.code, m_tdata[11:8]);
						error_count++;
					end
				end
			end
		end
	end

	// result side: random stalls plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= !rx_idle_on || ($urandom_range(99) >= 28);
		end
	end

	function automatic logic [31:0] reg_value(reg_idx_t idx);
		case (idx)
			REG_SHORT_TH: return {16'd0, cfg_short_th};
			REG_LONG_TH:  return {16'd0, cfg_long_th};
			REG_REPEAT:   return {16'd0, cfg_repeat};
			REG_DBL_WIN:  return {16'd0, cfg_dbl_win};
			REG_FALLTHRU: return {31'd0, cfg_fallthru};
			REG_DBL_EN:   return {31'd0, cfg_dbl_en};
			default:      return '0;
		endcase
	endfunction

	// psel stays up between back-to-back transfers, apb_release drops it
	task automatic apb_write(int unsigned idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'(idx * 4);
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_SHORT_TH: cfg_short_th = val[15:0];
			REG_LONG_TH:  cfg_long_th  = val[15:0];
			REG_REPEAT:   cfg_repeat   = val[15:0];
			REG_DBL_WIN:  cfg_dbl_win  = val[15:0];
			REG_FALLTHRU: cfg_fallthru = val[0];
			REG_DBL_EN:   cfg_dbl_en   = val[0];
			default: ;
		endcase
	endtask

	task automatic apb_read(reg_idx_t idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= AddrW'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata != reg_value(idx)) begin
			$error("prdata[%0d]: expected %0h, got %0h", idx, reg_value(idx), prdata);
			error_count++;
		end
	endtask

	task automatic apb_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_all_regs();
		for (int i = REG_SHORT_TH; i <= REG_DBL_EN; i++)
			apb_read(reg_idx_t'(i));
		apb_release();
	endtask

	// junk in the upper bits must be dropped by the block
	task automatic configure(logic [15:0] sh, logic [15:0] lg, logic [15:0] rp,
			logic [15:0] wn, logic ft, logic db);
		apb_write(REG_SHORT_TH, {16'($urandom), sh});
		apb_write(REG_LONG_TH,  {16'($urandom), lg});
		apb_write(REG_REPEAT,   {16'($urandom), rp});
		apb_write(REG_DBL_WIN,  {16'($urandom), wn});
		apb_write(REG_FALLTHRU, {31'($urandom), ft});
		apb_write(REG_DBL_EN,   {31'($urandom), db});
		apb_write(UnmappedIdx, $urandom());
		read_all_regs();
	endtask

	task automatic send_sample(logic [7:0] keys, logic [31:0] now, pinned_t pin);
		while (tx_idle_on && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		pin_q.push_back(pin);
		s_tvalid <= 1'b1;
		s_tdata  <= {now, keys};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		samples_sent++;
	endtask

	// steps sized around the current thresholds so that every one gets crossed
	function automatic logic [31:0] next_stamp();
		int unsigned r;
		logic [31:0] step;
		r = $urandom_range(19);
		if (r < 2)
			step = 0;
		else if (r < 7)
			step = $urandom_range(1, 8);
		else if (r == 7)
			step = cfg_short_th + $urandom_range(2);
		else if (r == 8)
			step = cfg_short_th / 2 + $urandom_range(3);
		else if (r < 11)
			step = cfg_long_th / 3 + $urandom_range(3);
		else if (r == 11)
			step = cfg_long_th + $urandom_range(2);
		else if (r < 14)
			step = cfg_repeat + $urandom_range(2);
		else if (r < 16)
			step = cfg_repeat / 2 + $urandom_range(3);
		else if (r < 18)
			step = cfg_dbl_win + $urandom_range(2) - 1;
		else if (r == 18)
			step = cfg_long_th + cfg_repeat;
		else
			step = $urandom();
		sample_ms = sample_ms + step;
		return sample_ms;
	endfunction

	// press, hold with narrowing or added keys, release, then the released step
	task automatic press_sequence();
		logic [7:0]  mask;
		logic [7:0]  part;
		int unsigned holds;
		if (last_mask != '0 && $urandom_range(1) == 1) begin
			mask = last_mask;
		end else begin
			case ($urandom_range(3))
				0: mask = 8'h01 << $urandom_range(7);
				1: mask = 8'hFF;
				default: mask = 8'($urandom_range(1, 255));
			endcase
		end
		holds = $urandom_range(1, 12);
		send_sample(mask, next_stamp(), '0);
		repeat (holds) begin
			case ($urandom_range(11))
				0: mask = mask | (8'h01 << $urandom_range(7));
				1: begin
					part = mask & 8'($urandom);
					if (part != '0)
						mask = part;
				end
				default: ;
			endcase
			send_sample(mask, next_stamp(), '0);
		end
		send_sample(8'h00, next_stamp(), '0);
		send_sample(8'($urandom), next_stamp(), '0);
		last_mask = mask;
	endtask

	task automatic run_random(int unsigned count);
		int unsigned target;
		target = samples_sent + count;
		while (samples_sent < target) begin
			if ($urandom_range(99) < 15)
				send_sample(8'($urandom), next_stamp(), '0);
			else
				press_sequence();
		end
	endtask

	// sender stops until every pending result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [15:0] sh, lg, rp, wn;
		logic        ft, db;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_all_regs();

		for (int i = 0; i < $size(DirRows); i++)
			send_sample(DirRows[i].keys, DirBase + DirRows[i].offset,
				pinned_t'{DirRows[i].pin, DirRows[i].exp_keys, DirRows[i].exp_code});

		sample_ms = $urandom();
		for (int p = 0; p < RandPhases; p++) begin
			settle();
			sh = $urandom_range(120);
			lg = $urandom_range(1500);
			rp = $urandom_range(400);
			wn = $urandom_range(500);
			ft = $urandom_range(1);
			db = $urandom_range(3) != 0;
			case (p)
				0: {sh, lg, rp, wn, ft, db} = {64'd0, 1'b1, 1'b1};
				1: {sh, lg, rp, wn, ft, db} = {{4{16'hFFFF}}, 1'b0, 1'b1};
				2: {sh, lg, ft, db} = {16'd200, 16'd40, 1'b1, 1'b0};  // long below short
				default: ;
			endcase
			configure(sh, lg, rp, wn, ft, db);
			case (p)
				3: begin
					// receiver holds off while the sender keeps offering
					tx_idle_on = 1'b0;
					hold_go   <= 1'b1;
				end
				4: begin
					tx_idle_on  = 1'b0;
					rx_idle_on <= 1'b0;
				end
				default: begin
					tx_idle_on  = 1'b1;
					rx_idle_on <= 1'b1;
				end
			endcase
			run_random(PhaseItems);
		end

		settle();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
